[hdl/mtrd_pkg.sv]
// ----------------------------------------------------------------------------
// mtrd_pkg
// Shared types and constants of the method trace record decoder: result
// codes, thread table sizing and the structs between core and thread table.
// ----------------------------------------------------------------------------
package mtrd_pkg;

	// thread table size and slot index width
	localparam int THREAD_SLOTS = 16;
	localparam int SLOT_W       = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

	// result status codes
	localparam logic [1:0] ST_RECORD  = 2'd0;
	localparam logic [1:0] ST_STOP    = 2'd1;
	localparam logic [1:0] ST_OVERRUN = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// packet type that carries records
	localparam logic [7:0] PKT_RECORDS = 8'd2;

	// one decoded result
	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        thread_num;
		logic               is_exit;
		logic signed [63:0] timestamp;
		logic [63:0]        method_num;
		logic signed [15:0] indent_depth;
	} res_t;

	// core to thread table
	typedef struct packed {
		logic [31:0]        key;
		logic               alloc;
		logic               wr;
		logic [SLOT_W-1:0]  wr_slot;
		logic signed [15:0] wr_depth;
	} tbl_req_t;

	// thread table to core
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  hit_slot;
		logic signed [15:0] hit_depth;
		logic               free;
		logic [SLOT_W-1:0]  free_slot;
	} tbl_rsp_t;

endpackage

[hdl/mtrd_thread_table.sv]
// ----------------------------------------------------------------------------
// mtrd_thread_table
// Small associative table of thread ids and call depths. Parallel tag compare
// against the lookup key, first free slot search, allocate and depth update.
// ----------------------------------------------------------------------------
module mtrd_thread_table (
	input  logic               clk,
	input  logic               arst_n,
	input  mtrd_pkg::tbl_req_t req,
	output mtrd_pkg::tbl_rsp_t rsp
);
	import mtrd_pkg::*;

	logic [31:0]             keys_q   [THREAD_SLOTS];
	logic signed [15:0]      depths_q [THREAD_SLOTS];
	logic [THREAD_SLOTS-1:0] valid_q;
	logic [THREAD_SLOTS-1:0] match;

	// tag compare, keys of valid slots are unique so matches are or-ed
	always_comb begin
		rsp = '0;
		for (int i = 0; i < THREAD_SLOTS; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == req.key);
			if (match[i]) begin
				rsp.hit_slot  = rsp.hit_slot | SLOT_W'(i);
				rsp.hit_depth = rsp.hit_depth | depths_q[i];
			end
		end
		rsp.hit = |match;
		// lowest free slot
		for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				rsp.free_slot = SLOT_W'(i);
			end
		end
		rsp.free = ~&valid_q;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.alloc) begin
			valid_q[rsp.free_slot] <= 1'b1;
		end
	end

	// keys and depths
	always_ff @(posedge clk) begin
		if (req.alloc) begin
			keys_q[rsp.free_slot]   <= req.key;
			depths_q[rsp.free_slot] <= '0;
		end else if (req.wr) begin
			depths_q[req.wr_slot] <= req.wr_depth;
		end
	end

`ifndef SYNTHESIS
	// allocation only for a missing thread with a free slot
	assert property (@(posedge clk) disable iff (!arst_n)
		req.alloc |-> (rsp.free && !rsp.hit))
		else $error("thread table allocate without free slot or on hit");
`endif

endmodule

[hdl/mtrd_core.sv]
// ----------------------------------------------------------------------------
// mtrd_core
// Per-byte packet parser: type byte, 11-byte header, signed LEB128 deltas,
// timestamp and method accumulation, call depth tracking and error halts.
// ----------------------------------------------------------------------------
module mtrd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_byte,
	output logic           emit,
	output mtrd_pkg::res_t res
);
	import mtrd_pkg::*;

	// parser phases
	localparam logic [2:0] PH_TYPE    = 3'd0;
	localparam logic [2:0] PH_HEADER  = 3'd1;
	localparam logic [2:0] PH_TIME    = 3'd2;
	localparam logic [2:0] PH_METHOD  = 3'd3;
	localparam logic [2:0] PH_SKIP    = 3'd4;
	localparam logic [2:0] PH_ERRPEND = 3'd5;

	localparam logic [3:0] HDR_LAST = 4'd10;
	localparam logic [3:0] LEB_LAST = 4'd9;

	logic [2:0]         phase_q,   phase_n;
	logic [3:0]         hdr_cnt_q, hdr_cnt_n;
	logic [31:0]        thread_q,  thread_n;
	logic [23:0]        records_q, records_n;
	logic [31:0]        payload_q, payload_n;
	logic [63:0]        tacc_q,    tacc_n;
	logic [63:0]        macc_q,    macc_n;
	logic [63:0]        leb_q,     leb_n;
	logic [3:0]         leb_cnt_q, leb_cnt_n;
	logic [63:0]        pend_q,    pend_n;
	logic [SLOT_W-1:0]  slot_q,    slot_n;
	logic signed [15:0] depth_q,   depth_n;
	logic               halted_q,  halted_n;

	logic [5:0]         leb_shamt;
	logic [5:0]         ext_shamt;
	logic [63:0]        leb_or;
	logic [63:0]        leb_val;
	logic               leb_done;
	logic [31:0]        payload_dec;
	logic [23:0]        records_dec;
	logic [63:0]        tacc_sum;
	logic [63:0]        macc_sum;
	logic [2:0]         finish_phase;
	logic               fin_exit;
	logic               finish;
	logic signed [15:0] depth_dn;
	logic signed [15:0] depth_up;
	tbl_req_t           tbl_req;
	tbl_rsp_t           tbl_rsp;

	mtrd_thread_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	// leb128 digit accumulate with sign extension on the final digit
	always_comb begin
		leb_shamt = 6'(7 * leb_cnt_q);
		ext_shamt = 6'(7 * (leb_cnt_q + 4'd1));
		leb_or    = leb_q | (64'(data_byte[6:0]) << leb_shamt);
		leb_done  = !data_byte[7] || (leb_cnt_q == LEB_LAST);
		leb_val   = leb_or;
		if (!data_byte[7] && data_byte[6] && (leb_cnt_q < LEB_LAST)) begin
			leb_val = leb_or | (~64'd0 << ext_shamt);
		end
	end

	// counters, sums and record close decisions
	always_comb begin
		payload_dec = payload_q - 32'd1;
		records_dec = records_q - 24'd1;
		tacc_sum    = tacc_q + leb_val;
		macc_sum    = macc_q + leb_val;
		if (records_dec == '0) begin
			finish_phase = (payload_dec != '0) ? PH_SKIP : PH_TYPE;
		end else if (payload_dec == '0) begin
			finish_phase = PH_ERRPEND;
		end else begin
			finish_phase = PH_TIME;
		end
	end

	// saturating depth update, both directions
	always_comb begin
		depth_dn = (depth_q != 16'sh8000) ? depth_q - 16'sd1 : depth_q;
		depth_up = (depth_q != 16'sh7fff) ? depth_q + 16'sd1 : depth_q;
	end

	// per-byte step
	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		thread_n  = thread_q;
		records_n = records_q;
		payload_n = payload_q;
		tacc_n    = tacc_q;
		macc_n    = macc_q;
		leb_n     = leb_q;
		leb_cnt_n = leb_cnt_q;
		pend_n    = pend_q;
		slot_n    = slot_q;
		depth_n   = depth_q;
		halted_n  = halted_q;
		emit      = 1'b0;
		finish    = 1'b0;
		fin_exit  = 1'b0;
		res              = '0;
		res.thread_num   = thread_q;
		tbl_req          = '0;
		tbl_req.key      = thread_q;
		tbl_req.wr_slot  = slot_q;

		if (step && !halted_q) begin
			unique case (phase_q)
				PH_TYPE: begin
					if (data_byte != PKT_RECORDS) begin
						halted_n       = 1'b1;
						emit           = 1'b1;
						res.status     = ST_STOP;
						res.thread_num = '0;
					end else begin
						phase_n   = PH_HEADER;
						hdr_cnt_n = '0;
						thread_n  = '0;
						records_n = '0;
						payload_n = '0;
					end
				end
				PH_HEADER: begin
					case (hdr_cnt_q)
						4'd0: thread_n[7:0]    = data_byte;
						4'd1: thread_n[15:8]   = data_byte;
						4'd2: thread_n[23:16]  = data_byte;
						4'd3: thread_n[31:24]  = data_byte;
						4'd4: records_n[7:0]   = data_byte;
						4'd5: records_n[15:8]  = data_byte;
						4'd6: records_n[23:16] = data_byte;
						4'd7: payload_n[7:0]   = data_byte;
						4'd8: payload_n[15:8]  = data_byte;
						4'd9: payload_n[23:16] = data_byte;
						default: payload_n[31:24] = data_byte;
					endcase
					hdr_cnt_n = hdr_cnt_q + 4'd1;
					if (hdr_cnt_q == HDR_LAST) begin
						hdr_cnt_n = '0;
						tacc_n    = '0;
						macc_n    = '0;
						leb_n     = '0;
						leb_cnt_n = '0;
						pend_n    = '0;
						if (payload_n == '0) begin
							phase_n = PH_TYPE;
						end else if (records_n == '0) begin
							phase_n = PH_SKIP;
						end else if (tbl_rsp.hit) begin
							slot_n  = tbl_rsp.hit_slot;
							depth_n = tbl_rsp.hit_depth;
							phase_n = PH_TIME;
						end else if (tbl_rsp.free) begin
							tbl_req.alloc = 1'b1;
							slot_n        = tbl_rsp.free_slot;
							depth_n       = '0;
							phase_n       = PH_TIME;
						end else begin
							phase_n    = PH_SKIP;
							emit       = 1'b1;
							res.status = ST_FULL;
						end
					end
				end
				PH_TIME, PH_METHOD: begin
					payload_n = payload_dec;
					if (!leb_done) begin
						leb_n     = leb_or;
						leb_cnt_n = leb_cnt_q + 4'd1;
						if (payload_dec == '0) begin
							halted_n   = 1'b1;
							emit       = 1'b1;
							res.status = ST_OVERRUN;
						end
					end else begin
						leb_n     = '0;
						leb_cnt_n = '0;
						if (phase_q == PH_TIME) begin
							tacc_n = tacc_sum;
							pend_n = tacc_sum;
							if (tacc_sum[0]) begin
								finish        = 1'b1;
								fin_exit      = 1'b1;
								res.timestamp = {tacc_sum[63:1], 1'b0};
							end else if (payload_dec == '0) begin
								halted_n   = 1'b1;
								emit       = 1'b1;
								res.status = ST_OVERRUN;
							end else begin
								phase_n = PH_METHOD;
							end
						end else begin
							macc_n         = macc_sum;
							finish         = 1'b1;
							res.method_num = macc_sum;
							res.timestamp  = {pend_q[63:1], 1'b0};
						end
					end
				end
				PH_SKIP: begin
					payload_n = payload_dec;
					if (payload_dec == '0) begin
						phase_n = PH_TYPE;
					end
				end
				PH_ERRPEND: begin
					halted_n   = 1'b1;
					emit       = 1'b1;
					res.status = ST_OVERRUN;
				end
				default: begin
					phase_n = PH_TYPE;
				end
			endcase

			// record close: emit with prior depth, write back new depth
			if (finish) begin
				emit             = 1'b1;
				res.status       = ST_RECORD;
				res.is_exit      = fin_exit;
				res.indent_depth = depth_q;
				depth_n          = fin_exit ? depth_dn : depth_up;
				tbl_req.wr       = 1'b1;
				tbl_req.wr_depth = depth_n;
				records_n        = records_dec;
				phase_n          = finish_phase;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE;
			hdr_cnt_q <= '0;
			thread_q  <= '0;
			records_q <= '0;
			payload_q <= '0;
			tacc_q    <= '0;
			macc_q    <= '0;
			leb_q     <= '0;
			leb_cnt_q <= '0;
			pend_q    <= '0;
			slot_q    <= '0;
			depth_q   <= '0;
			halted_q  <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			hdr_cnt_q <= hdr_cnt_n;
			thread_q  <= thread_n;
			records_q <= records_n;
			payload_q <= payload_n;
			tacc_q    <= tacc_n;
			macc_q    <= macc_n;
			leb_q     <= leb_n;
			leb_cnt_q <= leb_cnt_n;
			pend_q    <= pend_n;
			slot_q    <= slot_n;
			depth_q   <= depth_n;
			halted_q  <= halted_n;
		end
	end

`ifndef SYNTHESIS
	// halt is sticky
	assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");

	// stop and overrun results always halt the parser
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (res.status == ST_STOP || res.status == ST_OVERRUN)) |=> halted_q)
		else $error("error result without halt");

	// nothing comes out once halted
	assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !emit)
		else $error("result emitted while halted");
`endif

endmodule

[hdl/method_trace_record_decoder.sv]
// ----------------------------------------------------------------------------
// method_trace_record_decoder
// Streaming decoder of method trace packets into entry and exit records.
// ----------------------------------------------------------------------------
// Takes one trace byte per clock while results are not stalled and gives at
// most one result per byte. A byte waits in an input register and is decoded
// into the output register once that is free, so one byte per cycle is
// sustained without backpressure; the per-byte step (LEB128 digit merge plus
// 64-bit accumulate, and a 16-way parallel thread tag compare at the end of
// each header) is combinational. Results: tuser carries the status (record,
// stopped on other packet type, record past payload, thread table full).
// After a stop or an overrun the decoder drops all bytes with no result
// until reset. The thread table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module method_trace_record_decoder (
	input  logic         clk,
	input  logic         arst_n,
	// input byte stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [183:0] m_tdata,   // [31:0] thread number, [32] is_exit, [96:33] timestamp,
	                                // [160:97] method number, [176:161] indent_depth, rest zero
	output logic [1:0]   m_tuser    // [1:0] status
);
	import mtrd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       step;
	logic       emit;
	res_t       res;
	res_t       res_q;

	// handshake: input stage moves when the result register can take a result
	assign out_free = !m_tvalid || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	mtrd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.emit      (emit),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	// output packing
	assign m_tuser = res_q.status;
	assign m_tdata = {7'd0, res_q.indent_depth, res_q.method_num, res_q.timestamp,
		res_q.is_exit, res_q.thread_num};

`ifndef SYNTHESIS
	// a held input byte is not consumed while the result register is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage lost a byte under backpressure");
`endif

endmodule

[tb/method_trace_record_decoder_tb.sv]
// ----------------------------------------------------------------------------
// method_trace_record_decoder_tb
// Self-checking testbench of the method trace record decoder.
// ----------------------------------------------------------------------------
// Trace files go byte by byte into the slave stream. Every accepted byte also
// runs through a behavioral copy of the packet parser, and each result on the
// master stream is checked field by field against the oldest prediction.
// The stimulus has three parts. A few directed packets come first: empty
// payload, no records, ten-byte numbers and wrapping accumulators. Random
// well-formed packets follow, under changing sender and receiver idling, and
// they fill the thread table. A closing unknown packet type or truncated
// packet halts the decoder, and the bytes after it must be dropped.
// ----------------------------------------------------------------------------
module method_trace_record_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtrd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_BYTES    = 260;
	localparam int MAX_REPORTS    = 40;
	localparam int POOL_THREADS   = 24;

	// parser position of the behavioral decoder
	typedef enum logic [2:0] {
		PARSE_TYPE,
		PARSE_HEADER,
		PARSE_TIME,
		PARSE_METHOD,
		PARSE_SKIP,
		PARSE_OVERRUN_NEXT
	} parse_e;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = '0;   // [7:0] data_byte
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [183:0] m_tdata;         // [31:0] thread number, [32] is_exit, [96:33] timestamp,
	                               // [160:97] method number, [176:161] indent_depth
	logic [1:0]   m_tuser;         // [1:0] status

	// idling of both sides in percent
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// bytes waiting for the driver and packet under construction
	logic [7:0]  trace_bytes[$];
	logic [7:0]  payload_bytes[$];
	bit          ts_odd = 1'b0;
	logic [31:0] known_threads[$];
	logic [31:0] thread_pool[$];
	int          pool_next = 0;

	// behavioral decoder state
	parse_e             parse_phase = PARSE_TYPE;
	int                 hdr_idx     = 0;
	logic [31:0]        hdr_thread  = '0;
	logic [23:0]        recs_left   = '0;
	logic [31:0]        pay_left    = '0;
	logic [63:0]        ts_acc      = '0;
	logic [63:0]        mid_acc     = '0;
	logic [63:0]        digit_acc   = '0;
	logic [63:0]        pend_ts     = '0;
	int                 digit_shift = 0;
	logic [31:0]        slot_key[THREAD_SLOTS];
	logic signed [15:0] slot_depth[THREAD_SLOTS];
	bit                 slot_used[THREAD_SLOTS] = '{default: 1'b0};
	int                 cur_slot    = 0;
	logic signed [15:0] cur_depth   = '0;
	bit                 stopped     = 1'b0;

	res_t expected_results[$];

	int errors         = 0;
	int bytes_accepted = 0;
	int exits_seen     = 0;
	int idle_cycles    = 0;
	int status_seen[4] = '{default: 0};

	method_trace_record_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// behavioral decoder
	// ------------------------------------------------------------------

	// find the thread of the header or give it a free slot
	function automatic bit claim_thread_slot();
		for (int i = 0; i < THREAD_SLOTS; i++) begin
			if (slot_used[i] && slot_key[i] == hdr_thread) begin
				cur_slot  = i;
				cur_depth = slot_depth[i];
				return 1'b1;
			end
		end
		for (int i = 0; i < THREAD_SLOTS; i++) begin
			if (!slot_used[i]) begin
				slot_used[i]  = 1'b1;
				slot_key[i]   = hdr_thread;
				slot_depth[i] = '0;
				cur_slot      = i;
				cur_depth     = '0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// emit a record and move the depth and the record count on
	function automatic res_t close_record(bit ex, logic [63:0] mid);
		res_t r;
		r              = '0;
		r.status       = ST_RECORD;
		r.thread_num   = hdr_thread;
		r.is_exit      = ex;
		r.timestamp    = {pend_ts[63:1], 1'b0};
		r.method_num   = mid;
		r.indent_depth = cur_depth;
		if (ex) begin
			if (cur_depth != 16'sh8000)
				cur_depth = cur_depth - 16'sd1;
		end else if (cur_depth != 16'sh7fff) begin
			cur_depth = cur_depth + 16'sd1;
		end
		slot_depth[cur_slot] = cur_depth;
		recs_left = recs_left - 24'd1;
		if (recs_left == 0)
			parse_phase = (pay_left != 0) ? PARSE_SKIP : PARSE_TYPE;
		else if (pay_left == 0)
			parse_phase = PARSE_OVERRUN_NEXT;
		else
			parse_phase = PARSE_TIME;
		return r;
	endfunction

	// payload ran out while a record was still open
	function automatic res_t halt_overrun();
		res_t r;
		r            = '0;
		r.status     = ST_OVERRUN;
		r.thread_num = hdr_thread;
		stopped      = 1'b1;
		return r;
	endfunction

	// one accepted byte through the parser, prediction queued if any
	task automatic decode_trace_byte(input logic [7:0] b);
		res_t        r;
		bit          emit;
		bit          complete;
		logic [63:0] delta;
		emit = 1'b0;
		r    = '0;
		if (!stopped) begin
			case (parse_phase)
			PARSE_TYPE: begin
				if (b != PKT_RECORDS) begin
					stopped  = 1'b1;
					r.status = ST_STOP;
					emit     = 1'b1;
				end else begin
					parse_phase = PARSE_HEADER;
					hdr_idx     = 0;
					hdr_thread  = '0;
					recs_left   = '0;
					pay_left    = '0;
				end
			end
			PARSE_HEADER: begin
				if (hdr_idx < 4)
					hdr_thread[8*hdr_idx +: 8] = b;
				else if (hdr_idx < 7)
					recs_left[8*(hdr_idx-4) +: 8] = b;
				else
					pay_left[8*(hdr_idx-7) +: 8] = b;
				hdr_idx++;
				if (hdr_idx == 11) begin
					hdr_idx     = 0;
					ts_acc      = '0;
					mid_acc     = '0;
					digit_acc   = '0;
					digit_shift = 0;
					pend_ts     = '0;
					if (pay_left == 0)
						parse_phase = PARSE_TYPE;
					else if (recs_left == 0)
						parse_phase = PARSE_SKIP;
					else if (!claim_thread_slot()) begin
						parse_phase  = PARSE_SKIP;
						r.status     = ST_FULL;
						r.thread_num = hdr_thread;
						emit         = 1'b1;
					end else
						parse_phase = PARSE_TIME;
				end
			end
			PARSE_TIME, PARSE_METHOD: begin
				pay_left = pay_left - 32'd1;
				// signed leb128 digit, cut after the tenth byte
				if (digit_shift < 64)
					digit_acc = digit_acc | ({57'd0, b[6:0]} << digit_shift);
				digit_shift += 7;
				complete = !b[7] || digit_shift >= 70;
				if (!b[7] && digit_shift < 64 && b[6])
					digit_acc = digit_acc | (~64'd0 << digit_shift);
				if (!complete) begin
					if (pay_left == 0) begin
						r    = halt_overrun();
						emit = 1'b1;
					end
				end else begin
					delta       = digit_acc;
					digit_acc   = '0;
					digit_shift = 0;
					if (parse_phase == PARSE_TIME) begin
						ts_acc  = ts_acc + delta;
						pend_ts = ts_acc;
						if (pend_ts[0]) begin
							r    = close_record(1'b1, 64'd0);
							emit = 1'b1;
						end else if (pay_left == 0) begin
							r    = halt_overrun();
							emit = 1'b1;
						end else
							parse_phase = PARSE_METHOD;
					end else begin
						mid_acc = mid_acc + delta;
						r       = close_record(1'b0, mid_acc);
						emit    = 1'b1;
					end
				end
			end
			PARSE_SKIP: begin
				pay_left = pay_left - 32'd1;
				if (pay_left == 0)
					parse_phase = PARSE_TYPE;
			end
			PARSE_OVERRUN_NEXT: begin
				r    = halt_overrun();
				emit = 1'b1;
			end
			default: begin
				parse_phase = PARSE_TYPE;
			end
			endcase
		end
		if (emit)
			expected_results.insert(expected_results.size(), r);
	endtask

	// ------------------------------------------------------------------
	// packet builder
	// ------------------------------------------------------------------

	// append one byte to the trace or to the packet under construction
	function automatic void add_trace_byte(logic [7:0] b);
		trace_bytes.insert(trace_bytes.size(), b);
	endfunction

	function automatic void add_payload_byte(logic [7:0] b);
		payload_bytes.insert(payload_bytes.size(), b);
	endfunction

	function automatic bit is_known(logic [31:0] tid);
		foreach (known_threads[i])
			if (known_threads[i] == tid)
				return 1'b1;
		return 1'b0;
	endfunction

	// one leb128 number, canonical or padded up to ten bytes
	function automatic void push_number(bit fix_bit0, bit bit0);
		logic signed [63:0] v;
		logic [7:0]         chunk;
		int                 first;
		int                 n;
		first = payload_bytes.size();
		if ($urandom_range(0, 99) < 75) begin
			v = $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
			do begin
				chunk = {1'b0, v[6:0]};
				v     = v >>> 7;
				if (!((v == 0 && !chunk[6]) || (v == -1 && chunk[6])))
					chunk[7] = 1'b1;
				add_payload_byte(chunk);
			end while (chunk[7]);
		end else begin
			n = $urandom_range(2, 10);
			for (int i = 0; i < n; i++) begin
				if (i < n - 1)
					chunk = 8'($urandom_range(0, 127)) | 8'h80;
				else if (n == 10)
					chunk = 8'($urandom);
				else
					chunk = 8'($urandom_range(0, 127));
				add_payload_byte(chunk);
			end
		end
		if (fix_bit0) begin
			chunk    = payload_bytes[first];
			chunk[0] = bit0;
			payload_bytes[first] = chunk;
		end
	endfunction

	// exit or entry: bit 0 of the timestamp delta sets the parity
	function automatic void push_record(bit exit_rec);
		push_number(1'b1, exit_rec ^ ts_odd);
		ts_odd = exit_rec;
		if (!exit_rec)
			push_number(1'b0, 1'b0);
	endfunction

	// header plus payload; cut drops trailing payload bytes
	function automatic void emit_packet(logic [31:0] tid, logic [23:0] count, int extra,
			int cut);
		logic [31:0] pay_size;
		repeat (cut) void'(payload_bytes.pop_back());
		pay_size = payload_bytes.size() + extra;
		add_trace_byte(PKT_RECORDS);
		for (int i = 0; i < 4; i++) add_trace_byte(tid[8*i +: 8]);
		for (int i = 0; i < 3; i++) add_trace_byte(count[8*i +: 8]);
		for (int i = 0; i < 4; i++) add_trace_byte(pay_size[8*i +: 8]);
		foreach (payload_bytes[i]) add_trace_byte(payload_bytes[i]);
		repeat (extra) add_trace_byte(8'($urandom));
		if (pay_size != 0 && count != 0 && !is_known(tid) && known_threads.size() < THREAD_SLOTS)
			known_threads.insert(known_threads.size(), tid);
		payload_bytes.delete();
		ts_odd = 1'b0;
	endfunction

	// well-formed packet with random content
	function automatic void random_packet();
		logic [31:0] tid;
		int          kind;
		int          n;
		if (known_threads.size() != 0 && $urandom_range(0, 1))
			tid = known_threads[$urandom_range(0, known_threads.size() - 1)];
		else if (pool_next < thread_pool.size())
			tid = thread_pool[pool_next++];
		else
			tid = thread_pool[$urandom_range(0, thread_pool.size() - 1)];
		kind = $urandom_range(0, 99);
		if (kind < 8)
			emit_packet(tid, 24'($urandom), 0, 0);
		else if (kind < 16)
			emit_packet(tid, 24'd0, $urandom_range(1, 6), 0);
		else begin
			n = $urandom_range(1, 6);
			repeat (n) push_record($urandom_range(0, 99) < 40);
			emit_packet(tid, 24'(n), $urandom_range(0, 1) ? $urandom_range(1, 3) : 0, 0);
		end
	endfunction

	// unknown packet type or truncated packet, then bytes that must be dropped
	function automatic void closing_packet();
		logic [7:0]  b;
		logic [23:0] count;
		int          n;
		int          cut;
		if ($urandom_range(0, 99) < 30) begin
			b = 8'($urandom_range(0, 254));
			if (b >= PKT_RECORDS)
				b = b + 8'd1;
			add_trace_byte(b);
		end else begin
			n = $urandom_range(2, 5);
			repeat (n) push_record($urandom_range(0, 99) < 40);
			cut = $urandom_range(1, 3);
			if (cut > payload_bytes.size() - 1)
				cut = payload_bytes.size() - 1;
			count = ($urandom_range(0, 3) == 0) ? 24'hffffff : 24'(n + $urandom_range(0, 2));
			emit_packet(known_threads[$urandom_range(0, known_threads.size() - 1)], count, 0, cut);
		end
		repeat (24) add_trace_byte(8'($urandom));
	endfunction

	task automatic wait_for_queue();
		while (trace_bytes.size() != 0 || s_tvalid) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// stream driver and receiver
	// ------------------------------------------------------------------

	// one byte request at a time, held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (trace_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= trace_bytes.pop_front();
			end else
				s_tvalid <= 1'b0;
		end
	end

	// random backpressure on results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// prediction and checking
	// ------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t mismatch in %s: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				bytes_accepted++;
				decode_trace_byte(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				status_seen[m_tuser]++;
				if (m_tuser == ST_RECORD && m_tdata[32])
					exits_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t unexpected result: expected none, actual status %0d data %h",
							$time, m_tuser, m_tdata);
				end else begin
					want = expected_results.pop_front();
					compare_field("status", {62'd0, want.status}, {62'd0, m_tuser});
					compare_field("thread_num", {32'd0, want.thread_num}, {32'd0, m_tdata[31:0]});
					compare_field("is_exit", {63'd0, want.is_exit}, {63'd0, m_tdata[32]});
					compare_field("timestamp", want.timestamp, m_tdata[96:33]);
					compare_field("method_num", want.method_num, m_tdata[160:97]);
					compare_field("indent_depth", {48'd0, want.indent_depth},
						{48'd0, m_tdata[176:161]});
					compare_field("padding", 64'd0, {57'd0, m_tdata[183:177]});
				end
			end
		end
	end

	// ends a run in which nothing moves any more
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL method_trace_record_decoder");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin
		int send_mix[4];
		int recv_mix[4];
		send_mix = '{0, 87, 0, 18};
		recv_mix = '{0, 0, 87, 18};
		for (int i = 0; i < POOL_THREADS; i++) thread_pool.insert(thread_pool.size(), $urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty payload with and without records, record count zero with skip
		emit_packet(32'h0000_0000, 24'd0, 0, 0);
		emit_packet(32'hffff_ffff, 24'd5, 0, 0);
		emit_packet(32'h1234_5678, 24'd0, 3, 0);
		// ten-byte numbers, wrap of the method number, multi-byte delta, trailing skip
		repeat (10) add_payload_byte(8'hff);
		add_payload_byte(8'h41);
		repeat (9) add_payload_byte(8'hff);
		add_payload_byte(8'h00);
		add_payload_byte(8'h00);
		add_payload_byte(8'h01);
		add_payload_byte(8'h81);
		add_payload_byte(8'h80);
		add_payload_byte(8'h01);
		emit_packet(32'h0000_0000, 24'd4, 2, 0);
		add_payload_byte(8'h7f);
		emit_packet(32'hffff_ffff, 24'd1, 0, 0);
		wait_for_queue();

		// random packets under each idling mix, the last one ends in a halt
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_mix[ph];
			recv_stall_pct = recv_mix[ph];
			while (trace_bytes.size() < PHASE_BYTES) random_packet();
			if (ph == 3)
				closing_packet();
			wait_for_queue();
		end

		// drain
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d trace bytes: %0d records (%0d exits), %0d table-full results",
			bytes_accepted, status_seen[ST_RECORD], exits_seen, status_seen[ST_FULL]);
		$display("halted by %0d stop and %0d overrun results, %0d threads in table",
			status_seen[ST_STOP], status_seen[ST_OVERRUN], known_threads.size());
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS method_trace_record_decoder");
		else
			$display("FAIL method_trace_record_decoder");
		$finish;
	end

endmodule
